// ===== rtl/hkd_pkg.sv =====
// Package: shared types, constants and translation functions for the keyboard report differ.
`default_nettype none
package hkd_pkg;

	localparam int KEY_SLOTS_DEF = 6;
	localparam int MAX_SLOTS     = 6;
	localparam int MOD_STEPS     = 6;
	localparam int CNT_W         = 3;

	localparam logic [7:0] CODE_SHIFT = 8'hE1;
	localparam logic [7:0] CODE_CTRL  = 8'hE0;
	localparam logic [7:0] CODE_ALT   = 8'hE2;

	localparam logic [7:0] MASK_SHIFT = 8'h22;
	localparam logic [7:0] MASK_CTRL  = 8'h11;
	localparam logic [7:0] MASK_ALT   = 8'h44;

	localparam logic [7:0] KEY_A      = 8'h04;
	localparam logic [7:0] KEY_Z      = 8'h1D;
	localparam logic [7:0] KEY_1      = 8'h1E;
	localparam logic [7:0] KEY_9      = 8'h26;
	localparam logic [7:0] KEY_0      = 8'h27;
	localparam logic [7:0] KEY_SPACE  = 8'h2C;
	localparam logic [7:0] KEY_BKSP   = 8'h2A;

	localparam logic [7:0] ASC_UPPER_A = 8'h41;
	localparam logic [7:0] ASC_LOWER_A = 8'h61;
	localparam logic [7:0] ASC_ONE     = 8'h31;
	localparam logic [6:0] ASC_ZERO    = 7'h30;
	localparam logic [6:0] ASC_SPACE   = 7'h20;
	localparam logic [6:0] ASC_BKSP    = 7'h08;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_REL,
		ST_PRS,
		ST_FLUSH
	} hkd_state_t;

	typedef struct packed {
		logic [7:0] key;
		logic       pressed;
		logic [6:0] ascii;
		logic       ascii_valid;
		logic       last;
	} hkd_event_t;

	function automatic logic [7:0] grp_code(input logic [1:0] g);
		logic [7:0] c;
		case (g)
			2'd0:    c = CODE_SHIFT;
			2'd1:    c = CODE_CTRL;
			2'd2:    c = CODE_ALT;
			default: c = CODE_ALT;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] grp_mask(input logic [1:0] g);
		logic [7:0] m;
		case (g)
			2'd0:    m = MASK_SHIFT;
			2'd1:    m = MASK_CTRL;
			2'd2:    m = MASK_ALT;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [6:0] to_ascii(input logic [7:0] code, input logic [7:0] mods);
		logic [7:0] t;
		logic       shift;
		shift = (mods & MASK_SHIFT) != 8'h00;
		t = 8'h00;
		if (code >= KEY_A && code <= KEY_Z) begin
			t = code - KEY_A + (shift ? ASC_UPPER_A : ASC_LOWER_A);
		end else if (code >= KEY_1 && code <= KEY_9) begin
			t = code - KEY_1 + ASC_ONE;
		end else if (code == KEY_0) begin
			t = {1'b0, ASC_ZERO};
		end else if (code == KEY_SPACE) begin
			t = {1'b0, ASC_SPACE};
		end else if (code == KEY_BKSP) begin
			t = {1'b0, ASC_BKSP};
		end
		return t[6:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hkd_match.sv =====
// Shared match unit: reports whether a keycode sits in any slot of a report row.
`default_nettype none
module hkd_match #(
	parameter int KEY_SLOTS = hkd_pkg::KEY_SLOTS_DEF
) (
	input  wire logic [7:0]                 key,
	input  wire logic [KEY_SLOTS-1:0][7:0]  row,
	output logic                            hit
);

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (row[i] == key) begin
				hit = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hkd_evbuf.sv =====
// Output register: holds one event beat until the consumer takes it.
`default_nettype none
module hkd_evbuf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire hkd_pkg::hkd_event_t ev,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output hkd_pkg::hkd_event_t     data
);

	logic                valid_q;
	hkd_pkg::hkd_event_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= ev;
		end
	end

	assign out_valid = valid_q;
	assign data      = data_q;

endmodule
`default_nettype wire

// ===== rtl/hid_keyboard_report_diff_top.sv =====
// Top level: boot-keyboard report differ with sequencer, match unit and output register.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, modifier, key_slot_* | sink
//  out     | out_valid, out_ready, event_key, pressed,| source
//          | ascii_char, ascii_valid, last            |
//
// A report passes through accept, six modifier steps, one match-unit step per slot for
// releases and again for presses, and a flush.
// The single match unit compares one keycode against a whole report row per cycle.
// Events are held one step in a lookahead register so the final one carries last.
// Reset clears the kept report to zero; a stalled output register holds the sequencer.
`default_nettype none
module hid_keyboard_report_diff_top #(
	parameter int KEY_SLOTS = hkd_pkg::KEY_SLOTS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] modifier,
	input  wire logic [7:0] key_slot_0,
	input  wire logic [7:0] key_slot_1,
	input  wire logic [7:0] key_slot_2,
	input  wire logic [7:0] key_slot_3,
	input  wire logic [7:0] key_slot_4,
	input  wire logic [7:0] key_slot_5,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      event_key,
	output logic            pressed,
	output logic [6:0]      ascii_char,
	output logic            ascii_valid,
	output logic            last
);

	localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CNT_W  = hkd_pkg::CNT_W;

	hkd_pkg::hkd_state_t state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;

	logic [7:0]                mod_q, prev_mod_q;
	logic [KEY_SLOTS-1:0][7:0] new_q, old_q;
	logic [hkd_pkg::MAX_SLOTS-1:0][7:0] slot_in;

	hkd_pkg::hkd_event_t pend_q, ev, push_ev, buf_data;
	logic                pend_v_q;
	logic                has_ev, advance, push, out_busy, buf_valid;

	logic [7:0]                m_key;
	logic [KEY_SLOTS-1:0][7:0] m_row;
	logic                      m_hit;
	logic [7:0]                rel, prs;
	logic [1:0]                grp;

	assign slot_in = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0};

	assign in_ready = (state_q == hkd_pkg::ST_IDLE);
	assign out_busy = buf_valid && !out_ready;

	assign rel = prev_mod_q & ~mod_q;
	assign prs = mod_q & ~prev_mod_q;
	assign grp = cnt_q[2:1];

	always_comb begin
		if (state_q == hkd_pkg::ST_REL) begin
			m_key = old_q[cnt_q[SLOT_W-1:0]];
			m_row = new_q;
		end else begin
			m_key = new_q[cnt_q[SLOT_W-1:0]];
			m_row = old_q;
		end
	end

	hkd_match #(.KEY_SLOTS(KEY_SLOTS)) u_match (
		.key (m_key),
		.row (m_row),
		.hit (m_hit)
	);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		has_ev  = 1'b0;
		advance = 1'b0;
		push    = 1'b0;
		ev      = '0;
		push_ev = pend_q;
		case (state_q)
			hkd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = hkd_pkg::ST_MOD;
					cnt_d   = '0;
				end
			end
			hkd_pkg::ST_MOD: begin
				ev.key     = hkd_pkg::grp_code(grp);
				ev.pressed = cnt_q[0];
				has_ev     = ((cnt_q[0] ? prs : rel) & hkd_pkg::grp_mask(grp)) != 8'h00;
				advance    = !(has_ev && pend_v_q && out_busy);
				if (advance) begin
					if (cnt_q == CNT_W'(hkd_pkg::MOD_STEPS - 1)) begin
						state_d = hkd_pkg::ST_REL;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			hkd_pkg::ST_REL, hkd_pkg::ST_PRS: begin
				ev.key = m_key;
				if (state_q == hkd_pkg::ST_PRS) begin
					ev.pressed     = 1'b1;
					ev.ascii       = hkd_pkg::to_ascii(m_key, mod_q);
					ev.ascii_valid = ev.ascii != 7'd0;
				end
				has_ev  = (m_key != 8'h00) && !m_hit;
				advance = !(has_ev && pend_v_q && out_busy);
				if (advance) begin
					if (cnt_q == CNT_W'(KEY_SLOTS - 1)) begin
						state_d = (state_q == hkd_pkg::ST_REL) ? hkd_pkg::ST_PRS
						                                       : hkd_pkg::ST_FLUSH;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			hkd_pkg::ST_FLUSH: begin
				advance      = !(pend_v_q && out_busy);
				push_ev.last = 1'b1;
				if (advance) begin
					state_d = hkd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hkd_pkg::ST_IDLE;
			end
		endcase
		if (state_q == hkd_pkg::ST_FLUSH) begin
			push = advance && pend_v_q;
		end else begin
			push = advance && has_ev && pend_v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hkd_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (advance && state_q == hkd_pkg::ST_FLUSH) begin
			pend_v_q <= 1'b0;
		end else if (advance && has_ev) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_ev) begin
			pend_q <= ev;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mod_q <= modifier;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				new_q[i] <= slot_in[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mod_q <= 8'h00;
			old_q      <= '0;
		end else if (advance && state_q == hkd_pkg::ST_FLUSH) begin
			prev_mod_q <= mod_q;
			old_q      <= new_q;
		end
	end

	hkd_evbuf u_evbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.ev        (push_ev),
		.out_ready (out_ready),
		.out_valid (buf_valid),
		.data      (buf_data)
	);

	assign out_valid   = buf_valid;
	assign event_key   = buf_data.key;
	assign pressed     = buf_data.pressed;
	assign ascii_char  = buf_data.ascii;
	assign ascii_valid = buf_data.ascii_valid;
	assign last        = buf_data.last;

endmodule
`default_nettype wire

// ===== bench/tb_hid_keyboard_report_diff_top.sv =====
// Testbench for the keyboard report differ: directed and random reports against a scoreboard.
`default_nettype none
module tb_hid_keyboard_report_diff_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hkd_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int RANDOM_REPORTS = 320;
	localparam int CHUNK = 40;
	localparam int TAIL_CYCLES = 60;

	typedef logic [7:0] key_row_t [MAX_SLOTS];

	typedef enum int {
		CALM,
		SEND_GAPS,
		RECV_STALLS,
		BOTH_SLOW
	} pressure_t;

	class key_event_board;
		hkd_event_t due_events[$];
		logic [7:0] held_mods;
		key_row_t held_keys;
		int faults;
		int checked;
		int reports;
		int quiet_reports;
		int longest_burst;
		int translated;

		function new();
			held_mods = '0;
			foreach (held_keys[i]) held_keys[i] = '0;
			faults = 0;
			checked = 0;
			reports = 0;
			quiet_reports = 0;
			longest_burst = 0;
			translated = 0;
		endfunction

		function bit has_key(key_row_t row, logic [7:0] code);
			for (int s = 0; s < KEY_SLOTS_DEF; s++) begin
				if (row[s] == code) return 1'b1;
			end
			return 1'b0;
		endfunction

		function logic [6:0] char_for(logic [7:0] code, logic [7:0] mods);
			if (code >= KEY_A && code <= KEY_Z) begin
				return 7'(code - KEY_A) + (((mods & MASK_SHIFT) != 0) ? 7'h41 : 7'h61);
			end
			if (code >= KEY_1 && code <= KEY_9) return 7'h31 + 7'(code - KEY_1);
			if (code == KEY_0) return 7'h30;
			if (code == KEY_SPACE) return 7'h20;
			if (code == KEY_BKSP) return 7'h08;
			return 7'h00;
		endfunction

		function hkd_event_t make_event(logic [7:0] code, logic down, logic [6:0] ch);
			hkd_event_t ev;
			ev.key = code;
			ev.pressed = down;
			ev.ascii = ch;
			ev.ascii_valid = (ch != 7'h00);
			ev.last = 1'b0;
			return ev;
		endfunction

		function void take_report(logic [7:0] mods, key_row_t keys);
			hkd_event_t burst[$];
			hkd_event_t ev;
			logic [7:0] masks[3];
			logic [7:0] codes[3];
			logic [7:0] gone;
			logic [7:0] came;
			masks = '{MASK_SHIFT, MASK_CTRL, MASK_ALT};
			codes = '{CODE_SHIFT, CODE_CTRL, CODE_ALT};
			gone = held_mods & ~mods;
			came = mods & ~held_mods;
			for (int g = 0; g < 3; g++) begin
				if ((gone & masks[g]) != 0) burst.push_back(make_event(codes[g], 1'b0, 7'h00));
				if ((came & masks[g]) != 0) burst.push_back(make_event(codes[g], 1'b1, 7'h00));
			end
			for (int s = 0; s < KEY_SLOTS_DEF; s++) begin
				if (held_keys[s] != 0 && !has_key(keys, held_keys[s])) begin
					burst.push_back(make_event(held_keys[s], 1'b0, 7'h00));
				end
			end
			for (int s = 0; s < KEY_SLOTS_DEF; s++) begin
				if (keys[s] != 0 && !has_key(held_keys, keys[s])) begin
					burst.push_back(make_event(keys[s], 1'b1, char_for(keys[s], mods)));
					if (char_for(keys[s], mods) != 0) translated++;
				end
			end
			foreach (burst[i]) begin
				ev = burst[i];
				ev.last = (i == burst.size() - 1);
				due_events.push_back(ev);
			end
			reports++;
			if (burst.size() == 0) quiet_reports++;
			if (burst.size() > longest_burst) longest_burst = burst.size();
			held_mods = mods;
			held_keys = keys;
		endfunction

		function void match_event(logic [7:0] key, logic down, logic [6:0] ch, logic ch_ok,
			logic fin);
			hkd_event_t want;
			if (due_events.size() == 0) begin
				faults++;
				if (faults <= 10) begin
					$display("unexpected event: key %h pressed %b ascii %h/%b last %b",
						key, down, ch, ch_ok, fin);
				end
				return;
			end
			want = due_events.pop_front();
			checked++;
			if (want.key !== key || want.pressed !== down || want.ascii !== ch
				|| want.ascii_valid !== ch_ok || want.last !== fin) begin
				faults++;
				if (faults <= 10) begin
					$display("event %0d mismatch: expected key %h pressed %b ascii %h/%b last %b",
						checked, want.key, want.pressed, want.ascii, want.ascii_valid,
						want.last);
					$display("  got key %h pressed %b ascii %h/%b last %b",
						key, down, ch, ch_ok, fin);
				end
			end
		endfunction

		function int pending();
			return due_events.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] modifier = '0;
	logic [7:0] key_slot_0 = '0;
	logic [7:0] key_slot_1 = '0;
	logic [7:0] key_slot_2 = '0;
	logic [7:0] key_slot_3 = '0;
	logic [7:0] key_slot_4 = '0;
	logic [7:0] key_slot_5 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] event_key;
	logic pressed;
	logic [6:0] ascii_char;
	logic ascii_valid;
	logic last;

	key_event_board board;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	int directed_count = 0;
	logic [7:0] cur_mods = '0;
	key_row_t cur_keys = '{default: 8'h00};

	hid_keyboard_report_diff_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.modifier(modifier),
		.key_slot_0(key_slot_0),
		.key_slot_1(key_slot_1),
		.key_slot_2(key_slot_2),
		.key_slot_3(key_slot_3),
		.key_slot_4(key_slot_4),
		.key_slot_5(key_slot_5),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_key(event_key),
		.pressed(pressed),
		.ascii_char(ascii_char),
		.ascii_valid(ascii_valid),
		.last(last)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.match_event(event_key, pressed, ascii_char, ascii_valid, last);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d events still due", cycle_count, board.pending());
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic set_pressure(input pressure_t p);
		case (p)
			CALM: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			SEND_GAPS: begin
				idle_pct = 46;
				stall_pct = 0;
			end
			RECV_STALLS: begin
				idle_pct = 0;
				stall_pct = 46;
			end
			default: begin
				idle_pct = 37;
				stall_pct = 37;
			end
		endcase
	endtask

	task automatic send_report(input logic [7:0] mods, input key_row_t keys);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		modifier <= mods;
		key_slot_0 <= keys[0];
		key_slot_1 <= keys[1];
		key_slot_2 <= keys[2];
		key_slot_3 <= keys[3];
		key_slot_4 <= keys[4];
		key_slot_5 <= keys[5];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.take_report(mods, keys);
	endtask

	task automatic apply(input logic [7:0] m, input logic [7:0] k0, input logic [7:0] k1,
		input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4, input logic [7:0] k5);
		key_row_t row;
		row[0] = k0;
		row[1] = k1;
		row[2] = k2;
		row[3] = k3;
		row[4] = k4;
		row[5] = k5;
		send_report(m, row);
		directed_count++;
	endtask

	function automatic logic [7:0] pick_key();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
		return 8'($urandom_range(8'h04, 8'h2D));
	endfunction

	task automatic next_report();
		int r;
		int src;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// hold: repeat the report unchanged
		end else if (r < 80) begin
			if ($urandom_range(0, 2) == 0) cur_mods ^= 8'(1 << $urandom_range(0, 7));
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
					0: cur_mods ^= MASK_SHIFT;
					1: cur_mods ^= MASK_CTRL;
					default: cur_mods ^= MASK_ALT;
				endcase
			end
			for (int s = 0; s < KEY_SLOTS_DEF; s++) begin
				if (cur_keys[s] != 0 && $urandom_range(0, 3) == 0) begin
					cur_keys[s] = 8'h00;
				end else if (cur_keys[s] == 0 && $urandom_range(0, 2) == 0) begin
					cur_keys[s] = pick_key();
				end
				if ($urandom_range(0, 19) == 0) begin
					src = $urandom_range(0, KEY_SLOTS_DEF - 1);
					cur_keys[s] = cur_keys[src];
				end
			end
		end else begin
			cur_mods = 8'($urandom);
			for (int s = 0; s < KEY_SLOTS_DEF; s++) begin
				cur_keys[s] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
			end
		end
		send_report(cur_mods, cur_keys);
	endtask

	initial begin
		pressure_t phases[4];
		board = new();
		phases = '{CALM, SEND_GAPS, RECV_STALLS, BOTH_SLOW};
		set_pressure(CALM);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apply(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		apply(8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		apply(8'h20, 8'h04, 8'h1D, 8'h00, 8'h00, 8'h00, 8'h00);
		apply(8'h11, 8'h1E, 8'h26, 8'h27, 8'h1D, 8'h03, 8'h00);
		apply(8'h44, 8'h2C, 8'h2A, 8'h28, 8'h2B, 8'h2D, 8'h1F);
		apply(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		apply(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		apply(8'h88, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00);
		apply(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		apply(8'h77, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
		apply(8'h00, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F);
		apply(8'h07, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15);
		apply(8'h70, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B);
		apply(8'h00, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21);
		apply(8'h00, 8'h21, 8'h20, 8'h1F, 8'h1E, 8'h1D, 8'h1C);
		apply(8'h08, 8'h22, 8'h20, 8'h24, 8'h25, 8'h26, 8'h27);
		apply(8'h02, 8'h80, 8'h40, 8'h01, 8'h02, 8'h08, 8'h10);
		apply(8'h55, 8'hFE, 8'h7F, 8'h00, 8'hE0, 8'hE1, 8'hE2);
		apply(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		for (int n = 0; n < RANDOM_REPORTS; n++) begin
			if (n % CHUNK == 0) set_pressure(phases[(n / CHUNK) % 4]);
			next_report();
		end
		@(negedge clk);
		in_valid <= 1'b0;
		set_pressure(CALM);
		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		board.faults += board.pending();

		$display("covered %0d reports (%0d directed, %0d without change), %0d events checked",
			board.reports, directed_count, board.quiet_reports, board.checked);
		$display("longest event burst %0d, %0d translated presses, %0d mismatches",
			board.longest_burst, board.translated, board.faults);
		if (board.faults == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
